@@ hw/rtl/nmdr_pkg.sv @@
// Package for the MIDI note duration recorder: item and result types,
// operation and state codes, controller/datapath command and status structs.
// Depends on nothing.
package nmdr_pkg;

    localparam logic [7:0] STATUS_TYPE_MASK = 8'hF0;
    localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
    localparam logic [7:0] STATUS_CHAN_MASK = 8'h0F;
    localparam logic       KIND_STOP        = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        is_three_byte;
        logic [7:0]  status_byte;
        logic [7:0]  key_number;
        logic [7:0]  strike_level;
        logic [31:0] time_now;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_key;
        logic [7:0]  out_level;
        logic [3:0]  out_channel;
        logic [31:0] held_time;
        logic [31:0] span_time;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ON,
        OP_OFF,
        OP_STOP
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_HELD_RD,
        S_HELD_USE,
        S_REL_RD,
        S_REL_USE,
        S_ON_WR,
        S_OFF_FIN,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic emit_held;
        logic emit_rel;
        logic off_step;
        logic off_finish;
        logic on_write;
        logic stop_clear;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic held_zero;
        logic rel_zero;
        logic held_end;
        logic rel_end;
    } t_stat;

    function automatic t_op f_decode(input t_in item);
        t_op op;
        op = OP_NONE;
        if (item.kind == KIND_STOP) begin
            op = OP_STOP;
        end else if (item.is_three_byte) begin
            if ((item.status_byte & STATUS_TYPE_MASK) == STATUS_NOTE_ON) begin
                op = OP_ON;
            end else if ((item.status_byte & STATUS_TYPE_MASK) == STATUS_NOTE_OFF) begin
                op = OP_OFF;
            end
        end
        return op;
    endfunction

endpackage

@@ hw/rtl/nmdr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nmdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/nmdr_ctrl.sv @@
// Controller for the note duration recorder: sequences table scans and emits.
// Depends on nmdr_pkg.
module nmdr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  nmdr_pkg::t_stat i_stat,
    output nmdr_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    nmdr_pkg::t_state r_state;
    nmdr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nmdr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nmdr_pkg::S_IDLE: begin
                if (i_start) n_state = nmdr_pkg::S_DECIDE;
            end
            nmdr_pkg::S_DECIDE: begin
                unique case (i_stat.op)
                    nmdr_pkg::OP_ON:
                        n_state = i_stat.rel_zero ? nmdr_pkg::S_ON_WR : nmdr_pkg::S_REL_RD;
                    nmdr_pkg::OP_OFF:
                        n_state = i_stat.held_zero ? nmdr_pkg::S_IDLE : nmdr_pkg::S_HELD_RD;
                    nmdr_pkg::OP_STOP: begin
                        priority if (!i_stat.held_zero) n_state = nmdr_pkg::S_HELD_RD;
                        else if (!i_stat.rel_zero) n_state = nmdr_pkg::S_REL_RD;
                        else n_state = nmdr_pkg::S_CLEAR;
                    end
                    default: n_state = nmdr_pkg::S_IDLE;
                endcase
            end
            nmdr_pkg::S_HELD_RD: n_state = nmdr_pkg::S_HELD_USE;
            nmdr_pkg::S_HELD_USE: begin
                if (!i_stat.held_end) begin
                    n_state = nmdr_pkg::S_HELD_RD;
                end else if (i_stat.op == nmdr_pkg::OP_OFF) begin
                    n_state = nmdr_pkg::S_OFF_FIN;
                end else begin
                    n_state = i_stat.rel_zero ? nmdr_pkg::S_CLEAR : nmdr_pkg::S_REL_RD;
                end
            end
            nmdr_pkg::S_REL_RD: n_state = nmdr_pkg::S_REL_USE;
            nmdr_pkg::S_REL_USE: begin
                if (!i_stat.rel_end) begin
                    n_state = nmdr_pkg::S_REL_RD;
                end else begin
                    n_state = (i_stat.op == nmdr_pkg::OP_ON) ? nmdr_pkg::S_ON_WR
                                                             : nmdr_pkg::S_CLEAR;
                end
            end
            nmdr_pkg::S_ON_WR:   n_state = nmdr_pkg::S_IDLE;
            nmdr_pkg::S_OFF_FIN: n_state = nmdr_pkg::S_IDLE;
            nmdr_pkg::S_CLEAR:   n_state = nmdr_pkg::S_IDLE;
            default:             n_state = nmdr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != nmdr_pkg::S_IDLE);
        unique case (r_state)
            nmdr_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            nmdr_pkg::S_DECIDE: begin
                o_cmd.idx_clr = 1'b1;
            end
            nmdr_pkg::S_HELD_USE: begin
                o_cmd.emit_held = (i_stat.op == nmdr_pkg::OP_STOP);
                o_cmd.off_step  = (i_stat.op == nmdr_pkg::OP_OFF);
                o_cmd.idx_inc   = !i_stat.held_end;
                o_cmd.idx_clr   = i_stat.held_end && (i_stat.op == nmdr_pkg::OP_STOP);
            end
            nmdr_pkg::S_REL_USE: begin
                o_cmd.emit_rel = 1'b1;
                o_cmd.idx_inc  = !i_stat.rel_end;
            end
            nmdr_pkg::S_ON_WR:   o_cmd.on_write   = 1'b1;
            nmdr_pkg::S_OFF_FIN: o_cmd.off_finish = 1'b1;
            nmdr_pkg::S_CLEAR:   o_cmd.stop_clear = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

@@ hw/rtl/nmdr_dpath.sv @@
// Datapath for the note duration recorder: held and released tables, counts,
// scan index, duration arithmetic and the result register.
// Depends on nmdr_pkg and nmdr_ram.
module nmdr_dpath #(
    parameter int NOTE_SLOTS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nmdr_pkg::t_in   i_item,
    input  nmdr_pkg::t_cmd  i_cmd,
    output nmdr_pkg::t_stat o_stat,
    output logic            o_valid,
    output nmdr_pkg::t_out  o_result
);

    localparam int IW   = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int CNTW = $clog2(NOTE_SLOTS + 1);
    localparam int EW   = 20 + TIME_BITS;
    localparam int RW   = EW + TIME_BITS;
    localparam logic [CNTW-1:0] SLOTS = CNTW'(NOTE_SLOTS);

    nmdr_pkg::t_op         r_op, n_op;
    logic [7:0]            r_key, n_key;
    logic [7:0]            r_level, n_level;
    logic [3:0]            r_chan, n_chan;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic [IW-1:0]         r_idx, n_idx;
    logic [CNTW-1:0]       r_keep, n_keep;
    logic                  r_found, n_found;
    logic [EW-1:0]         r_first, n_first;
    logic [CNTW-1:0]       r_held_cnt, n_held_cnt;
    logic [CNTW-1:0]       r_rel_cnt, n_rel_cnt;
    logic                  r_valid, n_valid;
    nmdr_pkg::t_out        r_out, n_out;

    logic                  held_we;
    logic [IW-1:0]         held_waddr;
    logic [EW-1:0]         held_wdata;
    logic [EW-1:0]         held_rdata;
    logic                  rel_we;
    logic [RW-1:0]         rel_wdata;
    logic [RW-1:0]         rel_rdata;
    logic [7:0]            h_key;
    logic [TIME_BITS-1:0]  h_press;
    logic [EW-1:0]         rel_entry;
    logic [TIME_BITS-1:0]  rel_press;
    logic [TIME_BITS-1:0]  rel_hold;
    logic [TIME_BITS-1:0]  held_span;
    logic [TIME_BITS-1:0]  rel_span;
    logic                  held_room;
    logic                  key_hit;

    nmdr_ram #(.WIDTH(EW), .DEPTH(NOTE_SLOTS)) u_held_ram (
        .i_clk  (i_clk),
        .i_we   (held_we),
        .i_waddr(held_waddr),
        .i_wdata(held_wdata),
        .i_raddr(r_idx),
        .o_rdata(held_rdata)
    );

    nmdr_ram #(.WIDTH(RW), .DEPTH(NOTE_SLOTS)) u_rel_ram (
        .i_clk  (i_clk),
        .i_we   (rel_we),
        .i_waddr(IW'(r_rel_cnt)),
        .i_wdata(rel_wdata),
        .i_raddr(r_idx),
        .o_rdata(rel_rdata)
    );

    always_comb begin
        h_key     = held_rdata[EW-1 -: 8];
        h_press   = held_rdata[TIME_BITS-1:0];
        rel_entry = rel_rdata[RW-1 -: EW];
        rel_press = rel_entry[TIME_BITS-1:0];
        rel_hold  = rel_rdata[TIME_BITS-1:0];
        held_span = r_now - h_press;
        rel_span  = r_now - rel_press;
        held_room = (r_held_cnt < SLOTS);
        key_hit   = (h_key == r_key);

        held_we    = (i_cmd.on_write && held_room) || (i_cmd.off_step && !key_hit);
        held_waddr = i_cmd.on_write ? IW'(r_held_cnt) : IW'(r_keep);
        held_wdata = i_cmd.on_write ? {r_key, r_level, r_chan, r_now} : held_rdata;

        rel_we    = i_cmd.off_finish && r_found && (r_rel_cnt < SLOTS);
        rel_wdata = {r_first, r_now - r_first[TIME_BITS-1:0]};

        o_stat.op        = r_op;
        o_stat.held_zero = (r_held_cnt == '0);
        o_stat.rel_zero  = (r_rel_cnt == '0);
        o_stat.held_end  = ((CNTW'(r_idx) + CNTW'(1)) == r_held_cnt);
        o_stat.rel_end   = ((CNTW'(r_idx) + CNTW'(1)) == r_rel_cnt);
    end

    always_comb begin
        n_op       = r_op;
        n_key      = r_key;
        n_level    = r_level;
        n_chan     = r_chan;
        n_now      = r_now;
        n_idx      = r_idx;
        n_keep     = r_keep;
        n_found    = r_found;
        n_first    = r_first;
        n_held_cnt = r_held_cnt;
        n_rel_cnt  = r_rel_cnt;
        n_valid    = 1'b0;
        n_out      = r_out;

        if (i_cmd.load) begin
            n_op    = nmdr_pkg::f_decode(i_item);
            n_key   = i_item.key_number;
            n_level = i_item.strike_level;
            n_chan  = 4'(i_item.status_byte & nmdr_pkg::STATUS_CHAN_MASK);
            n_now   = TIME_BITS'(i_item.time_now);
        end

        if (i_cmd.idx_clr) begin
            n_idx   = '0;
            n_keep  = '0;
            n_found = 1'b0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IW'(1);
        end

        if (i_cmd.off_step) begin
            if (key_hit) begin
                if (!r_found) begin
                    n_first = held_rdata;
                    n_found = 1'b1;
                end
            end else begin
                n_keep = r_keep + CNTW'(1);
            end
        end

        if (i_cmd.off_finish) begin
            n_held_cnt = r_keep;
            if (rel_we) n_rel_cnt = r_rel_cnt + CNTW'(1);
        end

        if (i_cmd.on_write) begin
            n_rel_cnt = '0;
            if (held_room) n_held_cnt = r_held_cnt + CNTW'(1);
        end

        if (i_cmd.stop_clear) begin
            n_held_cnt = '0;
            n_rel_cnt  = '0;
        end

        if (i_cmd.emit_held) begin
            n_valid           = 1'b1;
            n_out.out_key     = h_key;
            n_out.out_level   = held_rdata[EW-9 -: 8];
            n_out.out_channel = held_rdata[TIME_BITS+3:TIME_BITS];
            n_out.held_time   = '0;
            n_out.span_time   = 32'(held_span);
            n_out.last        = o_stat.held_end && o_stat.rel_zero;
        end else if (i_cmd.emit_rel) begin
            n_valid           = 1'b1;
            n_out.out_key     = rel_entry[EW-1 -: 8];
            n_out.out_level   = rel_entry[EW-9 -: 8];
            n_out.out_channel = rel_entry[TIME_BITS+3:TIME_BITS];
            n_out.held_time   = 32'(rel_hold);
            n_out.span_time   = 32'(rel_span);
            n_out.last        = o_stat.rel_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op       <= nmdr_pkg::OP_NONE;
            r_idx      <= '0;
            r_keep     <= '0;
            r_found    <= 1'b0;
            r_held_cnt <= '0;
            r_rel_cnt  <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_op       <= n_op;
            r_idx      <= n_idx;
            r_keep     <= n_keep;
            r_found    <= n_found;
            r_held_cnt <= n_held_cnt;
            r_rel_cnt  <= n_rel_cnt;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_level <= n_level;
        r_chan  <= n_chan;
        r_now   <= n_now;
        r_first <= n_first;
        r_out   <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

@@ hw/rtl/midi_note_duration_recorder.sv @@
// MIDI note duration recorder top level: controller, datapath and table RAMs.
// Steps: an ignored item or a note-off on an empty table returns to idle from the decision;
// note-on scans each released note, note-off each held note, and stop every note.
// Each result needs a read state and a use state, as the table RAMs read registered.
// Reset (synchronous, active low) empties both tables; the receiver cannot stall.
module midi_note_duration_recorder #(
    parameter int NOTE_SLOTS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  nmdr_pkg::t_in  i_item,
    output logic           o_valid,
    output nmdr_pkg::t_out o_result
);

    nmdr_pkg::t_cmd  cmd;
    nmdr_pkg::t_stat stat;

    nmdr_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    nmdr_dpath #(
        .NOTE_SLOTS(NOTE_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_result(o_result)
    );

endmodule

@@ hw/rtl/nmdr_checker.sv @@
// Port-level checker for the MIDI note duration recorder, bound to the top.
// Depends on nmdr_pkg.
module nmdr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           i_busy,
    input logic           i_valid,
    input nmdr_pkg::t_out i_result
);

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_busy)
        else $error("result transfer while not busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("accepted item did not raise busy");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> !i_valid)
        else $error("result transfer right after accept");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_result.last) |=> !i_valid)
        else $error("result transfer right after last");

endmodule

bind midi_note_duration_recorder nmdr_checker u_nmdr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_valid (o_valid),
    .i_result(o_result)
);

@@ dv/tb_midi_note_duration_recorder.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for midi_note_duration_recorder: a scoreboard class predicts
// the note results of every accepted transfer and checks each strobed result in order.
// Depends on nmdr_pkg and the midi_note_duration_recorder RTL.
module tb_midi_note_duration_recorder;

    localparam int NOTE_SLOTS = 16;

    typedef struct packed {
        logic [7:0]  key;
        logic [7:0]  level;
        logic [3:0]  chan;
        logic [31:0] press;
    } t_note_rec;

    class note_timing_board;
        t_note_rec      held_tab[NOTE_SLOTS];
        int             held_count;
        t_note_rec      rel_tab[NOTE_SLOTS];
        logic [31:0]    rel_hold[NOTE_SLOTS];
        int             rel_count;
        nmdr_pkg::t_out expected_notes[$];
        int             errors;
        int             checked;
        int             drops;
        int             live_msgs;
        int             ignored_msgs;

        function nmdr_pkg::t_out make_res(t_note_rec n, logic [31:0] held,
                                          logic [31:0] now);
            nmdr_pkg::t_out r;
            r.out_key     = n.key;
            r.out_level   = n.level;
            r.out_channel = n.chan;
            r.held_time   = held;
            r.span_time   = now - n.press;
            r.last        = 1'b0;
            return r;
        endfunction

        function void record_transfer(nmdr_pkg::t_in it);
            nmdr_pkg::t_out batch[$];
            t_note_rec      first;
            logic           found;
            logic [7:0]     msg_type;
            int             keep;
            int             i;
            found    = 1'b0;
            keep     = 0;
            first    = '0;
            msg_type = it.status_byte & nmdr_pkg::STATUS_TYPE_MASK;
            if (it.kind == nmdr_pkg::KIND_STOP) begin
                live_msgs++;
                for (i = 0; i < held_count; i++)
                    batch = {batch, make_res(held_tab[i], 32'd0, it.time_now)};
                for (i = 0; i < rel_count; i++)
                    batch = {batch, make_res(rel_tab[i], rel_hold[i], it.time_now)};
                held_count = 0;
                rel_count  = 0;
            end else if (it.is_three_byte && msg_type == nmdr_pkg::STATUS_NOTE_ON) begin
                live_msgs++;
                for (i = 0; i < rel_count; i++)
                    batch = {batch, make_res(rel_tab[i], rel_hold[i], it.time_now)};
                rel_count = 0;
                if (held_count < NOTE_SLOTS) begin
                    held_tab[held_count].key   = it.key_number;
                    held_tab[held_count].level = it.strike_level;
                    held_tab[held_count].chan  = it.status_byte[3:0];
                    held_tab[held_count].press = it.time_now;
                    held_count++;
                end else begin
                    drops++;
                end
            end else if (it.is_three_byte && msg_type == nmdr_pkg::STATUS_NOTE_OFF) begin
                live_msgs++;
                for (i = 0; i < held_count; i++) begin
                    if (held_tab[i].key == it.key_number) begin
                        if (!found) begin
                            first = held_tab[i];
                            found = 1'b1;
                        end
                    end else begin
                        held_tab[keep] = held_tab[i];
                        keep++;
                    end
                end
                held_count = keep;
                if (found && rel_count < NOTE_SLOTS) begin
                    rel_tab[rel_count]  = first;
                    rel_hold[rel_count] = it.time_now - first.press;
                    rel_count++;
                end
            end else begin
                ignored_msgs++;
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            expected_notes = {expected_notes, batch};
        endfunction

        function void check_result(nmdr_pkg::t_out got);
            nmdr_pkg::t_out want;
            if (expected_notes.size() == 0) begin
                $error("result with nothing expected: out_key %0d", got.out_key);
                errors++;
                return;
            end
            want = expected_notes.pop_front();
            checked++;
            if (got.out_key !== want.out_key) begin
                $error("out_key expected %0d actual %0d", want.out_key, got.out_key);
                errors++;
            end
            if (got.out_level !== want.out_level) begin
                $error("out_level expected %0d actual %0d", want.out_level, got.out_level);
                errors++;
            end
            if (got.out_channel !== want.out_channel) begin
                $error("out_channel expected %0d actual %0d", want.out_channel,
                       got.out_channel);
                errors++;
            end
            if (got.held_time !== want.held_time) begin
                $error("held_time expected %0d actual %0d", want.held_time, got.held_time);
                errors++;
            end
            if (got.span_time !== want.span_time) begin
                $error("span_time expected %0d actual %0d", want.span_time, got.span_time);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    nmdr_pkg::t_in  i_item;
    logic           o_valid;
    nmdr_pkg::t_out o_result;

    note_timing_board board;
    logic             gaps_on;
    logic [31:0]      tick;

    midi_note_duration_recorder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                board.check_result(o_result);
            if (start && !busy)
                board.record_transfer(i_item);
        end
    end

    function automatic nmdr_pkg::t_in midi_msg(logic [7:0] status, logic [7:0] key,
                                               logic [7:0] level, logic [31:0] t);
        nmdr_pkg::t_in it;
        it.kind          = 1'b0;
        it.is_three_byte = 1'b1;
        it.status_byte   = status;
        it.key_number    = key;
        it.strike_level  = level;
        it.time_now      = t;
        return it;
    endfunction

    function automatic nmdr_pkg::t_in stop_msg(logic [31:0] t);
        nmdr_pkg::t_in it;
        it          = nmdr_pkg::t_in'({$urandom(), $urandom(), $urandom()});
        it.kind     = nmdr_pkg::KIND_STOP;
        it.time_now = t;
        return it;
    endfunction

    task automatic push_item(input nmdr_pkg::t_in it);
        start  = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic random_item(output nmdr_pkg::t_in it);
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            tick = $urandom();
        else
            tick = tick + $urandom_range(0, 400);
        if (pick < 8) begin
            it               = nmdr_pkg::t_in'({$urandom(), $urandom(), $urandom()});
            it.kind          = 1'b0;
            it.is_three_byte = 1'($urandom_range(0, 1));
            it.time_now      = tick;
        end else if (pick < 13) begin
            it = stop_msg(tick);
        end else if (pick < 60) begin
            it = midi_msg({nmdr_pkg::STATUS_NOTE_ON[7:4], 4'($urandom_range(0, 15))},
                          ($urandom_range(0, 9) < 7) ? 8'($urandom_range(60, 67))
                                                     : 8'($urandom()),
                          8'($urandom()), tick);
        end else begin
            it = midi_msg({nmdr_pkg::STATUS_NOTE_OFF[7:4], 4'($urandom_range(0, 15))},
                          8'($urandom()), 8'($urandom()), tick);
            if (board.held_count > 0 && $urandom_range(0, 99) < 85)
                it.key_number =
                    board.held_tab[4'($urandom_range(0, board.held_count - 1))].key;
        end
    endtask

    initial begin
        nmdr_pkg::t_in it;
        int            k;
        board   = new();
        gaps_on = 1'b1;
        tick    = 32'd1000;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        push_item(stop_msg(32'd7));
        it               = midi_msg(nmdr_pkg::STATUS_NOTE_ON, 8'd40, 8'd90, 32'd10);
        it.is_three_byte = 1'b0;
        push_item(it);
        push_item(midi_msg(8'hB5, 8'd40, 8'd90, 32'd12));
        push_item(midi_msg(nmdr_pkg::STATUS_NOTE_ON, 8'd0, 8'd0, 32'hFFFF_FFF0));
        push_item(midi_msg(nmdr_pkg::STATUS_NOTE_ON | nmdr_pkg::STATUS_CHAN_MASK,
                           8'd255, 8'd255, 32'd5));
        push_item(midi_msg(nmdr_pkg::STATUS_NOTE_ON | 8'h03, 8'd60, 8'd64, 32'd20));
        push_item(midi_msg(nmdr_pkg::STATUS_NOTE_ON | 8'h07, 8'd60, 8'd100, 32'd30));
        push_item(midi_msg(nmdr_pkg::STATUS_NOTE_OFF | 8'h07, 8'd60, 8'd0, 32'd45));
        push_item(midi_msg(nmdr_pkg::STATUS_NOTE_OFF, 8'd99, 8'd0, 32'd50));
        push_item(midi_msg(nmdr_pkg::STATUS_NOTE_ON | 8'h01, 8'd1, 8'd127, 32'd60));
        push_item(midi_msg(nmdr_pkg::STATUS_NOTE_OFF | nmdr_pkg::STATUS_CHAN_MASK,
                           8'd255, 8'd255, 32'd3));
        for (k = 0; k < 15; k++)
            push_item(midi_msg(nmdr_pkg::STATUS_NOTE_ON | 8'(k), 8'(k + 2), 8'(k * 17),
                               32'(100 + k)));
        push_item(stop_msg(32'hFFFF_FFFF));

        while (board.live_msgs + board.ignored_msgs < 170) begin
            gaps_on = (board.live_msgs + board.ignored_msgs < 140);
            random_item(it);
            push_item(it);
        end
        push_item(stop_msg(tick + 32'd50));
        start = 1'b0;

        while (board.expected_notes.size() != 0 || busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Drove %0d note and stop transfers plus %0d ignored messages.",
                 board.live_msgs, board.ignored_msgs);
        $display("Checked %0d results; %0d notes dropped on a full held table.",
                 board.checked, board.drops);
        if (board.errors == 0 && board.expected_notes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
